[sv/bilinear_grid_interpolator_assert.svh]
// Assertion macros for the bilinear grid interpolator.
// No dependencies; included by modules that check their own logic.
`ifndef BILINEAR_GRID_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_GRID_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BGI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BGI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BGI_ASSERT_IMP(label, clk, rst, ante, cons)
`define BGI_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/bgi_pkg.sv]
// Package for the bilinear grid interpolator: sizes, codes, types.
// No dependencies.
`default_nettype none
package bgi_pkg;
   localparam int MaxZenith  = 32;
   localparam int MaxAzimuth = 64;
   localparam int ZW = $clog2(MaxZenith);
   localparam int AW = $clog2(MaxAzimuth);
   localparam int TW = ZW + AW;

   localparam logic [1:0] MODE_LOAD_ZEN = 2'd0;
   localparam logic [1:0] MODE_LOAD_AZI = 2'd1;
   localparam logic [1:0] MODE_LOAD_TAB = 2'd2;
   localparam logic [1:0] MODE_QUERY    = 2'd3;

   localparam logic CSR_ZEN_COUNT = 1'b0;
   localparam logic CSR_AZI_COUNT = 1'b1;

   // Q_CAP = 2^40
   localparam logic [40:0] QCAP = 41'h100_0000_0000;

   // divider command / status
   typedef struct packed {
      logic        start;
      logic [31:0] y1;
      logic [31:0] y2;
      logic [32:0] x1;  // axis values, sign extended
      logic [32:0] x2;
      logic [32:0] x;
   } lerp_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
      logic        clip;
   } lerp_rsp_type;
endpackage
`default_nettype wire

[sv/bgi_lerp.sv]
// Iterative linear interpolation unit: a multiply step, then (unless trivial) a
// restoring divider one quotient bit per cycle. Uses bgi_pkg.
`default_nettype none
`include "bilinear_grid_interpolator_assert.svh"
module bgi_lerp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  bgi_pkg::lerp_cmd_type  cmd,
   output bgi_pkg::lerp_rsp_type  rsp
);
   import bgi_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] a_ff, a_in;     // |dy|
   logic [33:0] b_ff, b_in;     // |dx|
   logic [33:0] c_ff, c_in;     // |d|
   logic [66:0] prod_ff, prod_in;
   logic [34:0] rem_ff, rem_in;
   logic [41:0] q_ff, q_in;
   logic        over_ff, over_in;
   logic        neg_ff, neg_in;
   logic [31:0] y1_ff, y1_in;
   logic        byp_ff, byp_in;
   lerp_rsp_type rsp_ff, rsp_in;

   logic [32:0] dy;
   logic [33:0] dx, dd;
   logic [34:0] rsh, rdiff;
   logic [41:0] qr;
   logic [42:0] qf;
   logic signed [43:0] res;

   always_comb begin
      dy = {cmd.y2[31], cmd.y2} - {cmd.y1[31], cmd.y1};
      dx = {cmd.x[32], cmd.x} - {cmd.x1[32], cmd.x1};
      dd = {cmd.x2[32], cmd.x2} - {cmd.x1[32], cmd.x1};
      rsh = {rem_ff[33:0], prod_ff[66]};
      rdiff = rsh - {1'b0, c_ff};
      qr = (q_ff >= {1'b0, QCAP}) ? {1'b0, QCAP} : q_ff;
      qf = over_ff ? {2'b0, QCAP} : {1'b0, qr};
      res = neg_ff ? ($signed({{12{y1_ff[31]}}, y1_ff}) - $signed({1'b0, qf}))
                   : ($signed({{12{y1_ff[31]}}, y1_ff}) + $signed({1'b0, qf}));

      state_in = state_ff; cnt_in = cnt_ff; a_in = a_ff; b_in = b_ff; c_in = c_ff;
      prod_in = prod_ff; rem_in = rem_ff; q_in = q_ff; over_in = over_ff;
      neg_in = neg_ff; y1_in = y1_ff; byp_in = byp_ff;
      rsp_in = rsp_ff; rsp_in.done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               y1_in  = cmd.y1;
               a_in   = dy[32] ? -dy : dy;
               b_in   = dx[33] ? -dx : dx;
               c_in   = dd[33] ? -dd : dd;
               neg_in = (dy[32] ^ dx[33]) ^ dd[33];
               byp_in = (cmd.x1 == cmd.x2) || (dy == '0) || (dx == '0);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in = a_ff * b_ff;
            rem_in = '0; q_in = '0; over_in = 1'b0;
            cnt_in = 7'd67;
            state_in = byp_ff ? ST_FIN : ST_DIV;
         end
         ST_DIV: begin
            if (q_ff[41:40] != 2'b00 && q_ff >= {1'b0, QCAP}) over_in = over_ff;
            if (q_ff > {1'b0, QCAP}) over_in = 1'b1;
            prod_in = {prod_ff[65:0], 1'b0};
            if (!rdiff[34]) begin
               rem_in = rdiff; q_in = {q_ff[40:0], 1'b1};
            end else begin
               rem_in = rsh; q_in = {q_ff[40:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) state_in = ST_FIN;
         end
         default: begin
            rsp_in.done = 1'b1;
            if (byp_ff) begin
               rsp_in.value = y1_ff; rsp_in.clip = 1'b0;
            end else begin
               if (!over_ff && (rem_ff >= {1'b0, c_ff} - rem_ff) && q_ff <= {1'b0, QCAP})
                  qf = {1'b0, qr} + 43'd1;
               res = neg_ff ? ($signed({{12{y1_ff[31]}}, y1_ff}) - $signed({1'b0, qf}))
                            : ($signed({{12{y1_ff[31]}}, y1_ff}) + $signed({1'b0, qf}));
               if (res > 44'sh7FFF_FFFF) begin
                  rsp_in.value = 32'h7FFF_FFFF; rsp_in.clip = 1'b1;
               end else if (res < -44'sh8000_0000) begin
                  rsp_in.value = 32'h8000_0000; rsp_in.clip = 1'b1;
               end else begin
                  rsp_in.value = res[31:0]; rsp_in.clip = 1'b0;
               end
            end
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_ff.done <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_ff.done <= rsp_in.done;
      end
      rsp_ff.value <= rsp_in.value; rsp_ff.clip <= rsp_in.clip;
      cnt_ff <= cnt_in; a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      prod_ff <= prod_in; rem_ff <= rem_in; q_ff <= q_in; over_ff <= over_in;
      neg_ff <= neg_in; y1_ff <= y1_in; byp_ff <= byp_in;
   end

   assign rsp = rsp_ff;

   `BGI_ASSERT_NXT(a_start_mul, clock, reset, state_ff == ST_IDLE && cmd.start, state_ff == ST_MUL)
   `BGI_ASSERT_IMP(a_done_fin, clock, reset, rsp_ff.done, $past(state_ff) == ST_FIN)
   `BGI_ASSERT_IMP(a_cnt_div, clock, reset, state_ff == ST_DIV, cnt_ff != 7'd0)
endmodule
`default_nettype wire

[sv/bilinear_grid_interpolator.sv]
// Bilinear grid interpolator, top level: storage, bracket search, sequencer.
// Depends on bgi_pkg and bgi_lerp.
// Loads are written when accepted. A query runs these steps in order: each axis scan
// reads an entry and then compares it (registered read, then compare), four read
// states fetch the bracket, then three lerps (the divide is skipped when trivial) through
// one shared multiply + 67-step restoring divider. Reset (synchronous, high) sets both counts to 2.
`default_nettype none
`include "bilinear_grid_interpolator_assert.svh"
module bilinear_grid_interpolator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [4:0]  req_row_index,
   input  wire logic [5:0]  req_col_index,
   input  wire logic [31:0] req_load_value,
   input  wire logic [31:0] req_query_zenith,
   input  wire logic [31:0] req_query_azimuth,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_interpolated,
   output logic             rsp_saturated,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);
   import bgi_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ZSCN = 4'd1;   // zenith scan
   localparam logic [3:0] S_ASCN = 4'd2;   // azimuth scan
   localparam logic [3:0] S_RD   = 4'd3;   // read bracket entries
   localparam logic [3:0] S_L1   = 4'd4;
   localparam logic [3:0] S_W1   = 4'd5;
   localparam logic [3:0] S_L2   = 4'd6;
   localparam logic [3:0] S_W2   = 4'd7;
   localparam logic [3:0] S_L3   = 4'd8;
   localparam logic [3:0] S_W3   = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;
   localparam logic [3:0] S_RD2  = 4'd11;
   localparam logic [3:0] S_RD3  = 4'd12;
   localparam logic [3:0] S_RD4  = 4'd13;

   logic [31:0] zen_mem [MaxZenith];
   logic [31:0] azi_mem [MaxAzimuth];
   logic [31:0] tab_mem [MaxZenith*MaxAzimuth];

   logic [5:0]  zcnt_ff;
   logic [6:0]  acnt_ff;
   logic [3:0]  state_ff, state_in;
   logic [31:0] qz_ff, qa_ff;
   logic [ZW:0] zi_ff, zi_in;
   logic [AW:0] ai_ff, ai_in;
   logic [ZW:0] nz, hz;
   logic [AW:0] na, ha;
   logic [31:0] zrd_ff, ard_ff, trd_ff;
   logic [ZW-1:0] zra;
   logic [AW-1:0] ara;
   logic [TW-1:0] tra;
   logic [31:0] z1_ff, z2_ff, a1_ff, a2_ff, t11_ff, t12_ff, t21_ff, t22_ff;
   logic [31:0] p1_ff;
   logic        flag_ff;
   logic [31:0] res_ff;
   logic        scan_hit;
   lerp_cmd_type cmd;
   lerp_rsp_type lrsp;

   // clamp counts to [2, max]
   always_comb begin
      nz = (zcnt_ff < 6'd2) ? (ZW+1)'(2) :
           ({1'b0, zcnt_ff} > 7'(MaxZenith)) ? (ZW+1)'(MaxZenith) : (ZW+1)'(zcnt_ff);
      na = (acnt_ff < 7'd2) ? (AW+1)'(2) :
           ({1'b0, acnt_ff} > 8'(MaxAzimuth)) ? (AW+1)'(MaxAzimuth) : (AW+1)'(acnt_ff);
      hz = (zi_ff == '0) ? (ZW+1)'(1) : (zi_ff >= nz) ? nz - (ZW+1)'(1) : zi_ff;
      ha = (ai_ff == '0) ? (AW+1)'(1) : (ai_ff >= na) ? na - (AW+1)'(1) : ai_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zcnt_ff <= 6'd2; acnt_ff <= 7'd2;
      end else if (csr_write) begin
         if (csr_index == CSR_ZEN_COUNT) zcnt_ff <= csr_data[5:0];
         else acnt_ff <= csr_data;
      end
   end

   // memory read addresses follow the sequencer
   always_comb begin
      zra = zi_ff[ZW-1:0];
      ara = ai_ff[AW-1:0];
      tra = {hz[ZW-1:0] - ZW'(1), ha[AW-1:0] - AW'(1)};
      case (state_ff)
         S_RD: begin
            zra = hz[ZW-1:0] - ZW'(1); ara = ha[AW-1:0] - AW'(1);
            tra = {hz[ZW-1:0] - ZW'(1), ha[AW-1:0] - AW'(1)};
         end
         S_RD2: begin
            zra = hz[ZW-1:0]; ara = ha[AW-1:0];
            tra = {hz[ZW-1:0] - ZW'(1), ha[AW-1:0]};
         end
         S_RD3: tra = {hz[ZW-1:0], ha[AW-1:0] - AW'(1)};
         S_RD4: tra = {hz[ZW-1:0], ha[AW-1:0]};
         default: ;
      endcase
   end

   wire load_acc = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (load_acc && req_mode == MODE_LOAD_ZEN) zen_mem[req_row_index] <= req_load_value;
      if (load_acc && req_mode == MODE_LOAD_AZI) azi_mem[req_col_index] <= req_load_value;
      if (load_acc && req_mode == MODE_LOAD_TAB)
         tab_mem[{req_row_index, req_col_index}] <= req_load_value;
      zrd_ff <= zen_mem[zra];
      ard_ff <= azi_mem[ara];
      trd_ff <= tab_mem[tra];
   end

   // scan compare uses the registered read of the entry at the current index
   always_comb begin
      scan_hit = 1'b0;
      if (state_ff == S_ZSCN) scan_hit = !($signed(zrd_ff) < $signed(qz_ff));
      if (state_ff == S_ASCN) scan_hit = !($signed(ard_ff) < $signed(qa_ff));
   end

   // scan: scan_prime_ff marks when the registered read holds the entry at the current index
   logic scan_prime_ff;
   always_comb begin
      state_in = state_ff; zi_in = zi_ff; ai_in = ai_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_mode == MODE_QUERY) begin
               state_in = S_ZSCN; zi_in = '0; ai_in = '0;
            end
         end
         S_ZSCN: begin
            if (scan_prime_ff) begin
               if (scan_hit) state_in = S_ASCN;
               else if (zi_ff + (ZW+1)'(1) >= nz) begin
                  zi_in = nz; state_in = S_ASCN;
               end else zi_in = zi_ff + (ZW+1)'(1);
            end
         end
         S_ASCN: begin
            if (scan_prime_ff) begin
               if (scan_hit) state_in = S_RD;
               else if (ai_ff + (AW+1)'(1) >= na) begin
                  ai_in = na; state_in = S_RD;
               end else ai_in = ai_ff + (AW+1)'(1);
            end
         end
         S_RD:  state_in = S_RD2;
         S_RD2: state_in = S_RD3;
         S_RD3: state_in = S_RD4;
         S_RD4: state_in = S_L1;
         S_L1: begin
            cmd.start = 1'b1; cmd.y1 = t11_ff; cmd.y2 = t12_ff;
            cmd.x1 = {a1_ff[31], a1_ff}; cmd.x2 = {a2_ff[31], a2_ff};
            cmd.x = {qa_ff[31], qa_ff}; state_in = S_W1;
         end
         S_W1: if (lrsp.done) state_in = S_L2;
         S_L2: begin
            cmd.start = 1'b1; cmd.y1 = t21_ff; cmd.y2 = t22_ff;
            cmd.x1 = {a1_ff[31], a1_ff}; cmd.x2 = {a2_ff[31], a2_ff};
            cmd.x = {qa_ff[31], qa_ff}; state_in = S_W2;
         end
         S_W2: if (lrsp.done) state_in = S_L3;
         S_L3: begin
            cmd.start = 1'b1; cmd.y1 = p1_ff; cmd.y2 = t22_ff;
            cmd.x1 = {z1_ff[31], z1_ff}; cmd.x2 = {z2_ff[31], z2_ff};
            cmd.x = {qz_ff[31], qz_ff}; state_in = S_W3;
         end
         S_W3: if (lrsp.done) state_in = S_OUT;
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; scan_prime_ff <= 1'b0; flag_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_prime_ff <= (state_in == state_ff) && (zi_in == zi_ff) && (ai_in == ai_ff);
         if (state_ff == S_IDLE) flag_ff <= 1'b0;
         else if (lrsp.done) flag_ff <= flag_ff | lrsp.clip;
      end
      zi_ff <= zi_in; ai_ff <= ai_in;
      if (req_valid && req_ready && req_mode == MODE_QUERY) begin
         qz_ff <= req_query_zenith; qa_ff <= req_query_azimuth;
      end
      if (state_ff == S_RD2) begin z1_ff <= zrd_ff; a1_ff <= ard_ff; t11_ff <= trd_ff; end
      if (state_ff == S_RD3) begin z2_ff <= zrd_ff; a2_ff <= ard_ff; t12_ff <= trd_ff; end
      if (state_ff == S_RD4) t21_ff <= trd_ff;
      if (state_ff == S_L1) t22_ff <= trd_ff;
      if (state_ff == S_W1 && lrsp.done) p1_ff <= lrsp.value;
      if (state_ff == S_W2 && lrsp.done) t22_ff <= lrsp.value;
      if (state_ff == S_W3 && lrsp.done) res_ff <= lrsp.value;
   end

   bgi_lerp u_lerp (.clock(clock), .reset(reset), .cmd(cmd), .rsp(lrsp));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_interpolated = res_ff;
   assign rsp_saturated = flag_ff;

   `BGI_ASSERT_IMP(a_busy, clock, reset, rsp_valid, !req_ready)
   `BGI_ASSERT_NXT(a_out_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BGI_ASSERT_IMP(a_zi_range, clock, reset, state_ff == S_RD, zi_ff <= nz)
endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for bilinear_grid_interpolator: directed table, then random
// grid loads and queries, checked against a bit-exact Q16.16 predictor.
// Depends on bgi_pkg and the block RTL.
`default_nettype none
module testbench;
   import bgi_pkg::*;

   // ---------------------------------------------------------------- signals
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   wire logic   req_ready;
   logic [1:0]  req_mode = MODE_LOAD_ZEN;
   logic [4:0]  req_row_index = '0;
   logic [5:0]  req_col_index = '0;
   logic [31:0] req_load_value = '0;
   logic [31:0] req_query_zenith = '0;
   logic [31:0] req_query_azimuth = '0;
   wire logic   rsp_valid;
   logic        rsp_ready = 1'b0;
   wire logic [31:0] rsp_interpolated;
   wire logic   rsp_saturated;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_ZEN_COUNT;
   logic [6:0]  csr_data = '0;

   bilinear_grid_interpolator dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- types
   typedef struct {
      logic [31:0] value;
      logic        sat;
   } grid_result_t;

   // one row of the directed stimulus; known=1 means the answer is typed in
   typedef struct {
      logic [1:0]  mode;
      logic [4:0]  row;
      logic [5:0]  col;
      logic [31:0] val;
      logic [31:0] qz;
      logic [31:0] qa;
      bit          known;
      logic [31:0] kval;
      logic        ksat;
   } stim_row_t;

   localparam int unsigned DRAIN_CYCLES = 420;  // drain() wait after the last result is back

   // ---------------------------------------------------------------- grid mirror
   int    zen_axis[MaxZenith];
   int    azi_axis[MaxAzimuth];
   int    grid_value[MaxZenith*MaxAzimuth];
   bit    grid_written[MaxZenith*MaxAzimuth];
   logic [5:0] zen_count_reg = 6'd2;
   logic [6:0] azi_count_reg = 7'd2;

   grid_result_t pending_results[$];
   int    error_count = 0;
   int    send_idle_pct = 0;
   int    rsp_stall_pct = 0;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR %0t: %s", $time, what);
   endtask

   function automatic int used_zen();
      return zen_count_reg < 2 ? 2 : (zen_count_reg > MaxZenith ? MaxZenith : zen_count_reg);
   endfunction

   function automatic int used_azi();
      return azi_count_reg < 2 ? 2 : (azi_count_reg > MaxAzimuth ? MaxAzimuth : azi_count_reg);
   endfunction

   // a*b/c rounded half up, capped at 2^40 (c > 0)
   function automatic longint scaled_quotient(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
      logic [127:0] prod;
      logic [127:0] quo;
      logic [127:0] rem;
      longint unsigned q;
      prod = 128'(a) * 128'(b);
      quo  = prod / 128'(c);
      rem  = prod % 128'(c);
      if (quo >= (128'd1 << 63)) return longint'(QCAP);
      q = quo[63:0];
      if (rem >= 128'(c) - rem) q++;
      if (q > 64'(QCAP)) q = 64'(QCAP);
      return longint'(q);
   endfunction

   // one linear step through (x1,y1),(x2,y2), saturated to 32 bits
   function automatic longint line_step(longint x1, longint x2, longint y1, longint y2,
                                        longint x, inout bit clip);
      longint dy, dx, d, q, r;
      bit     neg;
      if (x1 == x2) return y1;
      dy  = y2 - y1;
      dx  = x - x1;
      d   = x2 - x1;
      neg = ((dy < 0) != (dx < 0)) != (d < 0);
      if (dy == 0 || dx == 0) return y1;
      q = scaled_quotient(dy < 0 ? -dy : dy, dx < 0 ? -dx : dx, d < 0 ? -d : d);
      r = neg ? y1 - q : y1 + q;
      if (r > 64'sh7FFF_FFFF) begin
         clip = 1'b1;
         return 64'sh7FFF_FFFF;
      end
      if (r < -64'sh8000_0000) begin
         clip = 1'b1;
         return -64'sh8000_0000;
      end
      return r;
   endfunction

   // first in-use entry at or above x, clamped to [1, n-1]
   function automatic int upper_zen(int n, longint x);
      int i;
      i = 0;
      while (i < n && longint'(zen_axis[i]) < x) i++;
      if (i == 0) return 1;
      return i >= n ? n - 1 : i;
   endfunction

   function automatic int upper_azi(int n, longint x);
      int i;
      i = 0;
      while (i < n && longint'(azi_axis[i]) < x) i++;
      if (i == 0) return 1;
      return i >= n ? n - 1 : i;
   endfunction

   function automatic grid_result_t interpolate_grid(logic [31:0] qz, logic [31:0] qa);
      grid_result_t res;
      bit     clip;
      int     i2, j2;
      longint z, a, p1, p2, p3;
      clip = 1'b0;
      z  = longint'($signed(qz));
      a  = longint'($signed(qa));
      i2 = upper_zen(used_zen(), z);
      j2 = upper_azi(used_azi(), a);
      p1 = line_step(azi_axis[j2-1], azi_axis[j2], grid_value[(i2-1)*MaxAzimuth + j2-1],
                     grid_value[(i2-1)*MaxAzimuth + j2], a, clip);
      p2 = line_step(azi_axis[j2-1], azi_axis[j2], grid_value[i2*MaxAzimuth + j2-1],
                     grid_value[i2*MaxAzimuth + j2], a, clip);
      p3 = line_step(zen_axis[i2-1], zen_axis[i2], p1, p2, z, clip);
      res.value = p3[31:0];
      res.sat   = clip;
      return res;
   endfunction

   // ---------------------------------------------------------------- request side
   // Drives one transaction and waits for it to be accepted. Valid is dropped only
   // when an idle gap is taken, so a back-to-back item keeps valid high.
   task automatic send_item(input logic [1:0] mode, input logic [4:0] row,
                            input logic [5:0] col, input logic [31:0] val,
                            input logic [31:0] qz, input logic [31:0] qa,
                            input bit known = 0, input logic [31:0] kval = '0,
                            input logic ksat = 1'b0);
      grid_result_t res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_mode          <= mode;
      req_row_index     <= row;
      req_col_index     <= col;
      req_load_value    <= val;
      req_query_zenith  <= qz;
      req_query_azimuth <= qa;
      req_valid         <= 1'b1;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge: update the mirror or queue the answer
      case (mode)
         MODE_LOAD_ZEN: zen_axis[row] = val;
         MODE_LOAD_AZI: azi_axis[col] = val;
         MODE_LOAD_TAB: begin
            grid_value[row*MaxAzimuth + col]   = val;
            grid_written[row*MaxAzimuth + col] = 1'b1;
         end
         default: begin
            if (known) begin
               res.value = kval;
               res.sat   = ksat;
            end else begin
               res = interpolate_grid(qz, qa);
            end
            pending_results.push_back(res);
         end
      endcase
   endtask

   // waits out every result, then the tail of any load still in flight
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_counts(input logic [6:0] zen, input logic [6:0] azi);
      csr_write <= 1'b1;
      csr_index <= CSR_ZEN_COUNT;
      csr_data  <= zen;
      @(posedge clock);
      zen_count_reg = zen[5:0];
      csr_index <= CSR_AZI_COUNT;
      csr_data  <= azi;
      @(posedge clock);
      azi_count_reg = azi;
      csr_write <= 1'b0;
   endtask

   // Rewrites both axes in ascending order (equal neighbors now and then) and
   // fills every in-use table entry that was never written.
   task automatic fill_grid();
      int v;
      v = -int'($urandom_range(32'h40_0000));
      for (int i = 0; i < used_zen(); i++) begin
         send_item(MODE_LOAD_ZEN, i[4:0], 6'($urandom), v, $urandom, $urandom);
         v += ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 32'h4_0000));
      end
      v = -int'($urandom_range(32'h40_0000));
      for (int j = 0; j < used_azi(); j++) begin
         send_item(MODE_LOAD_AZI, 5'($urandom), j[5:0], v, $urandom, $urandom);
         v += ($urandom_range(9) == 0) ? 0 : int'($urandom_range(1, 32'h4_0000));
      end
      for (int i = 0; i < used_zen(); i++)
         for (int j = 0; j < used_azi(); j++)
            if (!grid_written[i*MaxAzimuth + j])
               send_item(MODE_LOAD_TAB, i[4:0], j[5:0], $urandom, $urandom, $urandom);
   endtask

   function automatic logic [31:0] pick_coord(int lo, int hi, int exact);
      case ($urandom_range(7))
         0, 1:    return exact;
         2:       return $urandom;
         default: return lo - int'($urandom_range(32'h2_0000)) +
                         int'($urandom_range(32'(hi - lo) + 32'h4_0000));
      endcase
   endfunction

   function automatic logic [31:0] pick_table_value();
      case ($urandom_range(7))
         0:       return $urandom;
         1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
      endcase
   endfunction

   // Mostly queries over the loaded grid; the rest rewrite table entries and,
   // less often, nudge an axis entry (which may leave the axis unordered).
   task automatic random_item();
      int nz, na, r, i, j;
      nz = used_zen();
      na = used_azi();
      r  = $urandom_range(99);
      i  = $urandom_range(nz - 1);
      j  = $urandom_range(na - 1);
      if (r < 55)
         send_item(MODE_QUERY, 5'($urandom), 6'($urandom), $urandom,
                   pick_coord(zen_axis[0], zen_axis[nz-1], zen_axis[i]),
                   pick_coord(azi_axis[0], azi_axis[na-1], azi_axis[j]));
      else if (r < 88)
         send_item(MODE_LOAD_TAB, i[4:0], j[5:0], pick_table_value(), $urandom, $urandom);
      else if (r < 95)
         send_item(MODE_LOAD_ZEN, i[4:0], 6'($urandom),
                   zen_axis[i] + int'($urandom_range(32'h2000)) - 32'h1000, $urandom, $urandom);
      else
         send_item(MODE_LOAD_AZI, 5'($urandom), j[5:0],
                   azi_axis[j] + int'($urandom_range(32'h2000)) - 32'h1000, $urandom, $urandom);
   endtask

   // ---------------------------------------------------------------- response side
   // Ready is re-rolled every cycle; the transaction is checked against the
   // oldest queued answer using values sampled before this edge's updates.
   always @(posedge clock) begin
      grid_result_t want;
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rsp_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", rsp_interpolated));
         end else begin
            want = pending_results.pop_front();
            if (rsp_interpolated !== want.value)
               report_mismatch($sformatf("interpolated %h, want %h",
                                         rsp_interpolated, want.value));
            if (rsp_saturated !== want.sat)
               report_mismatch($sformatf("saturated %b, want %b", rsp_saturated, want.sat));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   stim_row_t directed[$];

   initial begin
      // config settings per phase: zenith, azimuth (clamped and extreme values)
      logic [6:0] zen_set[8] = '{7'd0,  7'd5, 7'd32, 7'h7F, 7'd2,  7'd3,   7'd9,  7'd1};
      logic [6:0] azi_set[8] = '{7'd1,  7'd7, 7'd2,  7'd3,  7'd64, 7'd127, 7'd13, 7'd0};
      int idle_send[4] = '{0, 53, 0, 12};
      int idle_rsp[4]  = '{0, 0, 53, 12};

      // grid at the reset counts (2 x 2): unit square with values 0,1,2,3
      directed.push_back('{MODE_LOAD_ZEN, 0, 0, 32'h0,       0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_ZEN, 1, 0, 32'h1_0000,  0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_AZI, 0, 0, 32'h0,       0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_AZI, 0, 1, 32'h1_0000,  0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_TAB, 0, 0, 32'h0,       0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_TAB, 0, 1, 32'h1_0000,  0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_TAB, 1, 0, 32'h2_0000,  0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_TAB, 1, 1, 32'h3_0000,  0, 0, 0, 0, 0});
      // corners, midpoint, extrapolation below both axes
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h0,      32'h0,      1, 32'h0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1, 32'h3_0000, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000,
                           1, 32'hFFFD_0000, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h8000, 32'h8000, 1, 32'h1_8000, 0});
      // coordinate extremes: far extrapolation, clipped
      directed.push_back('{MODE_QUERY, 31, 63, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                           0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0});
      // value extremes in the table
      directed.push_back('{MODE_LOAD_TAB, 1, 1, 32'h7FFF_FFFF, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_LOAD_TAB, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h4000, 32'hC000, 0, 0, 0});
      // zero-width zenith bracket, then zero-width azimuth bracket
      directed.push_back('{MODE_LOAD_ZEN, 1, 0, 32'h0, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h8000, 32'h8000, 0, 0, 0});
      directed.push_back('{MODE_LOAD_AZI, 0, 1, 32'h0, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'h12_3456, 32'hFFFF_FFFB, 0, 0, 0});
      // descending zenith axis
      directed.push_back('{MODE_LOAD_ZEN, 1, 0, 32'hFFFF_0000, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_QUERY, 0, 0, 0, 32'hFFFF_8000, 32'h0, 0, 0, 0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k])
         send_item(directed[k].mode, directed[k].row, directed[k].col, directed[k].val,
                   directed[k].qz, directed[k].qa, directed[k].known, directed[k].kval,
                   directed[k].ksat);
      drain();

      // random phases: new counts, fresh axes, then mixed traffic under one idle pattern
      for (int p = 0; p < 8; p++) begin
         write_counts(zen_set[p], azi_set[p]);
         send_idle_pct = idle_send[p % 4];
         rsp_stall_pct = idle_rsp[p % 4];
         fill_grid();
         repeat (155) random_item();
         drain();   // sender holds off until every answer is back
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
+incdir+sv
sv/bgi_pkg.sv
sv/bgi_lerp.sv
sv/bilinear_grid_interpolator.sv
tb/testbench.sv
